// ===== hdl/dbat_pkg.sv =====
// Shared types and constants for the disk block address translator.
// Field widths, status and register codes, and the records carried down the pipeline.
// No dependencies.
package dbat_pkg;

  localparam int unsigned OFF_W    = 32;
  localparam int unsigned LEN_W    = 31;
  localparam int unsigned PSTART_W = 28;
  localparam int unsigned PEND_W   = 29;
  localparam int unsigned LSEC_W   = 29;
  localparam int unsigned SEC_W    = 8;
  localparam int unsigned CYL_W    = 16;
  localparam int unsigned HEAD_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned BYTE_W   = 14;
  localparam int unsigned SPT_W    = 8;
  localparam int unsigned HC_W     = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 4;

  localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
  localparam logic [HC_W-1:0]  HC_RESET  = 5'd16;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OFFLINE = 2'd1,
    STAT_WRITE   = 2'd2,
    STAT_RANGE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ONLINE = 2'd0,
    REG_LBA    = 2'd1,
    REG_SPT    = 2'd2,
    REG_HEADS  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    status_e             status;
    logic [CNT_W-1:0]    cnt;
    logic [BYTE_W-1:0]   bytes;
    logic [LSEC_W-1:0]   lsec;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [SPT_W-1:0]    trk_rem;
  } side2_t;

  typedef struct packed {
    status_e             status;
    logic [SEC_W-1:0]    sec;
    logic [CYL_W-1:0]    cyl;
    logic [HEAD_W-1:0]   head;
    logic [CNT_W-1:0]    cnt;
    logic [BYTE_W-1:0]   bytes;
  } res_t;

endpackage

// ===== hdl/disk_block_address_translate.sv =====
// Top level of the disk block address translator: register port, front stages, output skid.
// Turns partition byte requests into task-file address fields and sector counts.
// Depends on dbat_pkg and dbat_div.
//
// The block accepts one request beat per clock while the skid register is empty, and
// returns one result beat per request, in order. Two front stages form the absolute
// sector and the count, then two pipelined restoring dividers of eight stages each
// (sector by sectors per track, then by heads, four quotient bits per stage) feed one
// output register. A skid register behind the output keeps the input open for one more
// beat while a result waits. Registers must be written only while no request is in
// flight; the block itself does not enforce this. SECTOR_BYTES and MAX_XFER_BYTES must
// be powers of two with SECTOR_BYTES not above MAX_XFER_BYTES.
module disk_block_address_translate
  import dbat_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES   = 512,
  parameter int unsigned MAX_XFER_BYTES = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                req_type_i,
  input  logic [OFF_W-1:0]    byte_offset_i,
  input  logic [LEN_W-1:0]    transfer_length_i,
  input  logic [PSTART_W-1:0] part_start_i,
  input  logic [PEND_W-1:0]   part_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [SEC_W-1:0]    sector_field_o,
  output logic [CYL_W-1:0]    cylinder_field_o,
  output logic [HEAD_W-1:0]   head_field_o,
  output logic [CNT_W-1:0]    sector_count_o,
  output logic [BYTE_W-1:0]   byte_count_o
);

  localparam int unsigned SHIFT  = $clog2(SECTOR_BYTES);
  localparam int unsigned RAW_W  = $clog2(MAX_XFER_BYTES / SECTOR_BYTES + 1);
  localparam int unsigned CAP_W  = $clog2(MAX_XFER_BYTES + 1);
  localparam int unsigned SUM_W  = CAP_W + 1;
  localparam int unsigned FULL_W = RAW_W + SHIFT;

  logic              online_q, lba_q;
  logic [SPT_W-1:0]  spt_q;
  logic [HC_W-1:0]   hc_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= 1'b0;
      lba_q    <= 1'b0;
      spt_q    <= SPT_RESET;
      hc_q     <= HC_RESET;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_ONLINE: online_q <= pwdata[0];
        REG_LBA:    lba_q    <= pwdata[0];
        REG_SPT:    spt_q    <= pwdata[SPT_W-1:0];
        REG_HEADS:  hc_q     <= pwdata[HC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_ONLINE: prdata = DATA_W'(online_q);
      REG_LBA:    prdata = DATA_W'(lba_q);
      REG_SPT:    prdata = DATA_W'(spt_q);
      REG_HEADS:  prdata = DATA_W'(hc_q);
      default:    prdata = '0;
    endcase
  end

  logic              en;
  logic              skid_v_q, skid_v_d;
  logic              out_v_q, out_v_d;
  res_t              out_q, skid_q, res;
  logic              load_out_pipe, load_out_skid, load_skid;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // Front stage A: absolute sector and raw sector count.
  logic              a_v_q;
  status_e           a_stat_q, a_stat_d;
  logic [LSEC_W-1:0] a_lsec_q, a_lsec_d;
  logic [PEND_W-1:0] a_pend_q;
  logic [RAW_W-1:0]  a_cnt_q, a_cnt_d;
  logic [CAP_W-1:0]  len_cap;
  logic [SUM_W-1:0]  len_sum;

  always_comb begin
    if (!online_q) begin
      a_stat_d = STAT_OFFLINE;
    end else if (req_type_i) begin
      a_stat_d = STAT_WRITE;
    end else begin
      a_stat_d = STAT_OK;
    end
    a_lsec_d = LSEC_W'(byte_offset_i >> SHIFT) + LSEC_W'(part_start_i);
    if (transfer_length_i > LEN_W'(MAX_XFER_BYTES)) begin
      len_cap = CAP_W'(MAX_XFER_BYTES);
    end else begin
      len_cap = CAP_W'(transfer_length_i);
    end
    len_sum = SUM_W'(len_cap) + SUM_W'(SECTOR_BYTES - 1);
    a_cnt_d = RAW_W'(len_sum >> SHIFT);
  end

  // Front stage B: range check, clipping at the partition end, byte count.
  logic              b_v_q;
  side_t             b_side_q, b_side_d;
  logic [LSEC_W-1:0] left;
  logic [RAW_W-1:0]  cnt_clip;
  logic [FULL_W-1:0] bytes_full;

  always_comb begin
    left       = LSEC_W'(a_pend_q) - a_lsec_q;
    cnt_clip   = (left < LSEC_W'(a_cnt_q)) ? RAW_W'(left) : a_cnt_q;
    bytes_full = {cnt_clip, {SHIFT{1'b0}}};
    b_side_d.lsec   = a_lsec_q;
    b_side_d.status = a_stat_q;
    b_side_d.cnt    = '0;
    b_side_d.bytes  = '0;
    if (a_stat_q == STAT_OK) begin
      if (LSEC_W'(a_pend_q) <= a_lsec_q) begin
        b_side_d.status = STAT_RANGE;
      end else begin
        b_side_d.cnt   = CNT_W'(cnt_clip);
        b_side_d.bytes = BYTE_W'(bytes_full);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_stat_q <= a_stat_d;
      a_lsec_q <= a_lsec_d;
      a_pend_q <= part_end_i;
      a_cnt_q  <= a_cnt_d;
      b_side_q <= b_side_d;
    end
  end

  logic [SPT_W-1:0]  spt_eff;
  logic [HC_W-1:0]   hc_eff;
  logic              d1_v, d2_v;
  logic [LSEC_W-1:0] d1_quo, d2_quo;
  logic [SPT_W-1:0]  d1_rem;
  logic [HC_W-1:0]   d2_rem;
  logic [$bits(side_t)-1:0]  d1_side;
  logic [$bits(side2_t)-1:0] d2_side;
  side2_t            d2_in_side, fin;

  assign spt_eff = (spt_q == '0) ? SPT_W'(1) : spt_q;
  assign hc_eff  = (hc_q == '0) ? HC_W'(1) : hc_q;

  dbat_div #(
    .NUM_W  (LSEC_W),
    .DEN_W  (SPT_W),
    .SIDE_W ($bits(side_t)),
    .STEP   (4)
  ) u_div_trk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .num_i   (b_side_q.lsec),
    .den_i   (spt_eff),
    .side_i  (b_side_q),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .rem_o   (d1_rem),
    .side_o  (d1_side)
  );

  assign d2_in_side.side    = side_t'(d1_side);
  assign d2_in_side.trk_rem = d1_rem;

  dbat_div #(
    .NUM_W  (LSEC_W),
    .DEN_W  (HC_W),
    .SIDE_W ($bits(side2_t)),
    .STEP   (4)
  ) u_div_cyl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d1_v),
    .num_i   (d1_quo),
    .den_i   (hc_eff),
    .side_i  (d2_in_side),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .rem_o   (d2_rem),
    .side_o  (d2_side)
  );

  assign fin = side2_t'(d2_side);

  always_comb begin
    res.status = fin.side.status;
    res.cnt    = fin.side.cnt;
    res.bytes  = fin.side.bytes;
    res.sec    = '0;
    res.cyl    = '0;
    res.head   = '0;
    if (fin.side.status == STAT_OK) begin
      if (lba_q) begin
        res.sec  = fin.side.lsec[7:0];
        res.cyl  = fin.side.lsec[23:8];
        res.head = fin.side.lsec[27:24];
      end else begin
        res.sec  = fin.trk_rem + SEC_W'(1);
        res.cyl  = d2_quo[CYL_W-1:0];
        res.head = d2_rem[HEAD_W-1:0];
      end
    end
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_v_d       = out_v_q;
    skid_v_d      = skid_v_q;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_v_q) begin
      if (out_ready_i) begin
        load_out_skid = 1'b1;
        skid_v_d      = 1'b0;
      end
    end else if (d2_v) begin
      if (!out_v_q || out_ready_i) begin
        load_out_pipe = 1'b1;
        out_v_d       = 1'b1;
      end else begin
        load_skid = 1'b1;
        skid_v_d  = 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_pipe) begin
      out_q <= res;
    end else if (load_out_skid) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_v_q;
  assign status_o         = out_q.status;
  assign sector_field_o   = out_q.sec;
  assign cylinder_field_o = out_q.cyl;
  assign head_field_o     = out_q.head;
  assign sector_count_o   = out_q.cnt;
  assign byte_count_o     = out_q.bytes;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a beat while the output register is empty");

  a_refused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.status != STAT_OK) |->
      (out_q.sec == '0 && out_q.cyl == '0 && out_q.head == '0 &&
       out_q.cnt == '0 && out_q.bytes == '0))
    else $error("refused request carries nonzero result fields");

  a_chs_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.status == STAT_OK && !lba_q && hc_eff <= HC_W'(16)) |->
      ({1'b0, out_q.head} < hc_eff && out_q.sec != '0))
    else $error("cylinder-head-sector fields out of range");

endmodule

// ===== hdl/dbat_div.sv =====
// Pipelined restoring divider giving quotient and remainder, STEP quotient bits per stage.
// A sideband word and a valid bit travel with each operand; all stages move on en_i.
// Depends on dbat_pkg.
module dbat_div
  import dbat_pkg::*;
#(
  parameter int unsigned NUM_W  = 29,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned STEP   = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NSTG  = (NUM_W + STEP - 1) / STEP;
  localparam int unsigned PAD_W = NSTG * STEP;

  logic              v_q    [NSTG];
  logic [PAD_W-1:0]  x_q    [NSTG];
  logic [PAD_W-1:0]  x_d    [NSTG];
  logic [DEN_W-1:0]  r_q    [NSTG];
  logic [DEN_W-1:0]  r_d    [NSTG];
  logic [DEN_W-1:0]  den_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  function automatic logic [PAD_W+DEN_W-1:0] div_steps(input logic [PAD_W-1:0] x_in,
                                                       input logic [DEN_W-1:0] r_in,
                                                       input logic [DEN_W-1:0] d);
    logic [PAD_W-1:0] x;
    logic [DEN_W-1:0] r;
    logic [DEN_W:0]   t;
    x = x_in;
    r = r_in;
    for (int i = 0; i < STEP; i++) begin
      t = {r, x[PAD_W-1]};
      x = {x[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        x[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    return {x, r};
  endfunction

  always_comb begin
    {x_d[0], r_d[0]} = div_steps(PAD_W'(num_i), '0, den_i);
    for (int s = 1; s < NSTG; s++) begin
      {x_d[s], r_d[s]} = div_steps(x_q[s-1], r_q[s-1], den_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTG; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < NSTG; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int s = 0; s < NSTG; s++) begin
        x_q[s] <= x_d[s];
        r_q[s] <= r_d[s];
      end
      for (int s = 1; s < NSTG; s++) begin
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign quo_o   = x_q[NSTG-1][NUM_W-1:0];
  assign rem_o   = r_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule
